// ----- src/sorted_key_priority_list_macros.svh -----
// Assertion macros for the sorted key priority list checker
`ifndef SORTED_KEY_PRIORITY_LIST_MACROS_SVH
`define SORTED_KEY_PRIORITY_LIST_MACROS_SVH
`define SKPL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: label failed");
`define SKPL_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label failed");
`endif

// ----- src/skpl_pkg.sv -----
// Types and codes shared by the sorted key priority list
package skpl_pkg;
  localparam logic [2:0] REQ_PREPEND = 3'd0;
  localparam logic [2:0] REQ_APPEND  = 3'd1;
  localparam logic [2:0] REQ_INSERT  = 3'd2;
  localparam logic [2:0] REQ_POP     = 3'd3;
  localparam logic [2:0] REQ_DELETE  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] entry_key;
    logic [31:0]        entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_value;
    logic [5:0]         entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } dp_sts_t;
endpackage

// ----- src/skpl_if.sv -----
// Valid/ready channel interfaces for requests and responses
interface skpl_req_if import skpl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface skpl_rsp_if import skpl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/skpl_ctrl.sv -----
// Controller: accepts a beat, drives the datapath, hands the response out
module skpl_ctrl import skpl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step  = (state_q == S_RUN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RUN;
      S_RUN:  if (sts_i.done) state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

// ----- src/skpl_dp.sv -----
// Datapath: slot memory, position scan and shift sequencer
module skpl_dp import skpl_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] base_key_i,
  input  req_t               req_i,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  output rsp_t               rsp_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    P_SCAN  = 7'b0000001,
    P_RD    = 7'b0000010,
    P_CHK   = 7'b0000100,
    P_MVRD  = 7'b0001000,
    P_MVWR  = 7'b0010000,
    P_WRITE = 7'b0100000,
    P_DONE  = 7'b1000000
  } phase_e;

  logic [63:0] mem [CAPACITY];
  logic [63:0] rd_q;

  phase_e             ph_q, ph_d;
  req_t               req_q, req_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic               ins_q, ins_d;
  logic signed [31:0] nkey_q, nkey_d;
  logic [1:0]         st_q, st_d;
  logic signed [31:0] okey_q, okey_d;
  logic [31:0]        oval_q, oval_d;

  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [63:0]        wdata;
  logic signed [31:0] rkey;
  logic signed [31:0] ekey;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_dec;
  logic               last;

  assign rkey    = rd_q[63:32];
  assign ekey    = req_q.entry_key;
  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);
  assign last    = (idx_inc >= cnt_q);

  assign sts_o.done = (ph_q == P_DONE);
  assign rsp_o.status = st_q;
  assign rsp_o.out_key = okey_q;
  assign rsp_o.out_value = oval_q;
  assign rsp_o.entry_count = 6'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // one read and one write per cycle; a move reads in P_MVRD, writes in P_MVWR
  always_comb begin
    raddr = idx_q[AW-1:0];
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rd_q;
    case (ph_q)
      P_MVRD: raddr = ins_q ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
      P_MVWR: we = 1'b1;
      P_WRITE: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = {nkey_q, req_q.entry_value};
      end
      default: ;
    endcase
  end

  always_comb begin
    ph_d   = ph_q;
    req_d  = req_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    ins_d  = ins_q;
    nkey_d = nkey_q;
    st_d   = st_q;
    okey_d = okey_q;
    oval_d = oval_q;
    if (cmd_i.load) begin
      req_d  = req_i;
      idx_d  = '0;
      pos_d  = '0;
      ins_d  = 1'b0;
      st_d   = ST_OK;
      okey_d = '0;
      oval_d = '0;
      ph_d   = P_SCAN;
    end else if (cmd_i.step) begin
      unique case (ph_q)
        P_SCAN: begin
          case (req_q.req_type) inside
            REQ_PREPEND, REQ_APPEND, REQ_INSERT: begin
              ins_d = 1'b1;
              if (cnt_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
                ph_d = P_DONE;
              end else if (cnt_q == '0) begin
                nkey_d = (req_q.req_type == REQ_INSERT) ? ekey : base_key_i;
                okey_d = (req_q.req_type == REQ_INSERT) ? ekey : base_key_i;
                ph_d   = P_WRITE;
              end else begin
                if (req_q.req_type == REQ_APPEND) idx_d = cnt_q - CW'(1);
                ph_d = P_RD;
              end
            end
            REQ_POP, REQ_DELETE: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                ph_d = P_DONE;
              end else begin
                ph_d = P_RD;
              end
            end
            default: ph_d = P_DONE;
          endcase
        end
        P_RD: ph_d = P_CHK;
        P_CHK: begin
          case (req_q.req_type)
            REQ_PREPEND: begin
              nkey_d = (rkey > KEY_MIN) ? rkey - 32'sd1 : KEY_MIN;
              okey_d = (rkey > KEY_MIN) ? rkey - 32'sd1 : KEY_MIN;
              pos_d  = '0;
              idx_d  = cnt_q;
              ph_d   = P_MVRD;
            end
            REQ_APPEND: begin
              nkey_d = (rkey < KEY_MAX) ? rkey + 32'sd1 : KEY_MAX;
              okey_d = (rkey < KEY_MAX) ? rkey + 32'sd1 : KEY_MAX;
              pos_d  = cnt_q;
              idx_d  = cnt_q;
              ph_d   = P_MVRD;
            end
            REQ_INSERT: begin
              nkey_d = ekey;
              okey_d = ekey;
              if (ekey >= rkey && !last) begin
                idx_d = idx_inc;
                ph_d  = P_RD;
              end else begin
                pos_d = (ekey >= rkey) ? idx_inc : idx_q;
                idx_d = cnt_q;
                ph_d  = P_MVRD;
              end
            end
            default: begin
              if (req_q.req_type == REQ_POP || rkey == ekey) begin
                okey_d = rkey;
                oval_d = rd_q[31:0];
                ph_d   = P_MVRD;
              end else if (last) begin
                st_d = ST_EMPTY;
                ph_d = P_DONE;
              end else begin
                idx_d = idx_inc;
                ph_d  = P_RD;
              end
            end
          endcase
        end
        P_MVRD: begin
          if (ins_q) begin
            if (idx_q == pos_q) ph_d = P_WRITE;
            else ph_d = P_MVWR;
          end else if (last) begin
            cnt_d = cnt_q - CW'(1);
            ph_d  = P_DONE;
          end else begin
            ph_d = P_MVWR;
          end
        end
        P_MVWR: begin
          idx_d = ins_q ? idx_dec : idx_inc;
          ph_d  = P_MVRD;
        end
        P_WRITE: begin
          cnt_d = cnt_q + CW'(1);
          ph_d  = P_DONE;
        end
        default: ph_d = P_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_DONE;
      req_q  <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      pos_q  <= '0;
      ins_q  <= 1'b0;
      nkey_q <= '0;
      st_q   <= ST_OK;
      okey_q <= '0;
      oval_q <= '0;
    end else begin
      ph_q   <= ph_d;
      req_q  <= req_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      ins_q  <= ins_d;
      nkey_q <= nkey_d;
      st_q   <= st_d;
      okey_q <= okey_d;
      oval_q <= oval_d;
    end
  end
endmodule

// ----- src/sorted_key_priority_list.sv -----
// Top level of the sorted key priority list
// Usage:
//   req carries beats of (req_type, entry_key, entry_value); each request
//   gives one response beat on rsp with (status, out_key, out_value,
//   entry_count). APB register 0 at address 0 is base_key; write it only
//   while no request is in flight.
// Sequencing:
//   One request at a time. The slot memory has one registered read port,
//   so the position scan reads and then checks one entry at a time
//   (P_RD, P_CHK), and the shift that opens or closes a gap reads and
//   then writes each moved entry (P_MVRD, P_MVWR). The next request can
//   be accepted in the cycle after the response beat is taken.
// Reset:
//   Clears the entry count and base_key; slot contents stay undefined and
//   are never read before written.
// Stall:
//   The response is held in registers while rsp.ready is low; no new
//   request is accepted until it is taken.
module sorted_key_priority_list import skpl_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skpl_req_if.sink    req,
  skpl_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic signed [31:0] base_key_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  rsp_t    rsp_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? base_key_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_key_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) base_key_q <= pwdata;
  end

  skpl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  skpl_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni,
    .base_key_i(base_key_q), .req_i(req.data),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp_data)
  );

  assign rsp.data = rsp_data;
endmodule

// ----- src/skpl_checker.sv -----
// Port-level checker for the sorted key priority list, bound to the top
`include "sorted_key_priority_list_macros.svh"
module skpl_checker import skpl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);
  `SKPL_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
  `SKPL_ASSERT(a_one_at_a_time, clk_i, rst_ni, rsp_valid |-> !req_ready)
  `SKPL_ASSERT(a_accept_busy, clk_i, rst_ni, req_valid && req_ready |=> !req_ready)
  `SKPL_ASSERT(a_status_code, clk_i, rst_ni, rsp_valid |-> rsp_data.status != 2'd3)
endmodule

bind sorted_key_priority_list skpl_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);

// ----- sim/tb_sorted_key_priority_list.sv -----
// Testbench for the sorted key priority list: random and directed requests checked by a scoreboard
`timescale 1ns / 100ps

import skpl_pkg::*;

class skpl_scoreboard;
  logic signed [31:0] keys[$];
  logic [31:0]        vals[$];
  logic signed [31:0] base_key;
  rsp_t               pending[$];
  int                 errors;

  function new();
    base_key = 0;
    errors = 0;
  endfunction

  function int count();
    return keys.size();
  endfunction

  function void note_request(req_t r);
    rsp_t o;
    logic signed [31:0] k;
    int pos;
    o = '0;
    if (r.req_type == REQ_PREPEND || r.req_type == REQ_APPEND ||
        r.req_type == REQ_INSERT) begin
      if (keys.size() >= 32) begin
        o.status = ST_FULL;
      end else if (r.req_type == REQ_PREPEND) begin
        k = base_key;
        if (keys.size() > 0) k = (keys[0] > KEY_MIN) ? keys[0] - 1 : KEY_MIN;
        keys.push_front(k);
        vals.push_front(r.entry_value);
        o.out_key = k;
      end else if (r.req_type == REQ_APPEND) begin
        k = base_key;
        if (keys.size() > 0) k = (keys[$] < KEY_MAX) ? keys[$] + 1 : KEY_MAX;
        keys.push_back(k);
        vals.push_back(r.entry_value);
        o.out_key = k;
      end else begin
        pos = 0;
        while (pos < keys.size() && r.entry_key >= keys[pos]) pos++;
        keys.insert(pos, r.entry_key);
        vals.insert(pos, r.entry_value);
        o.out_key = r.entry_key;
      end
    end else if (r.req_type == REQ_POP) begin
      if (keys.size() == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.out_key = keys.pop_front();
        o.out_value = vals.pop_front();
      end
    end else if (r.req_type == REQ_DELETE) begin
      pos = -1;
      foreach (keys[i]) if (pos < 0 && keys[i] == r.entry_key) pos = i;
      if (pos < 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.out_key = keys[pos];
        o.out_value = vals[pos];
        keys.delete(pos);
        vals.delete(pos);
      end
    end
    o.entry_count = 6'(keys.size());
    pending.push_back(o);
  endfunction

  function void check_response(rsp_t a);
    rsp_t e;
    if (pending.size() == 0) begin
      $error("response beat with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, a.status); errors++;
    end
    if (a.out_key !== e.out_key) begin
      $error("out_key expected %0d actual %0d", e.out_key, a.out_key); errors++;
    end
    if (a.out_value !== e.out_value) begin
      $error("out_value expected %h actual %h", e.out_value, a.out_value); errors++;
    end
    if (a.entry_count !== e.entry_count) begin
      $error("entry_count expected %0d actual %0d", e.entry_count, a.entry_count);
      errors++;
    end
  endfunction
endclass

module tb_sorted_key_priority_list;
  import skpl_pkg::*;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int cycles = 0;

  skpl_req_if req ();
  skpl_rsp_if rsp ();
  skpl_scoreboard sb;

  sorted_key_priority_list DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 800000) begin
      $display("sorted_key_priority_list test failed");
      $finish;
    end
    if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.data);
  end

  // response side backpressure
  initial begin
    int n;
    rsp.ready = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      rsp.ready <= 1;
      n = $urandom_range(1, 7);
      repeat (n) @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        rsp.ready <= 0;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send(logic [2:0] t, logic signed [31:0] k, logic [31:0] v);
    req_t r;
    int n;
    r.req_type = t;
    r.entry_key = k;
    r.entry_value = v;
    req.valid <= 1;
    req.data <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
    n = gap_len();
    if (n > 0) begin
      req.valid <= 0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic apb_write(logic signed [31:0] v);
    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 2'd0; pwdata <= v; penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.base_key = v;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_key(int mode);
    if (mode == 0) return $urandom_range(0, 15) - 8;
    if (mode == 1) return $urandom_range(0, 1) ? KEY_MAX - $urandom_range(0, 3)
                                               : KEY_MIN + $urandom_range(0, 3);
    return $urandom;
  endfunction

  initial begin
    int mode, t, fill;
    logic signed [31:0] k;
    sb = new();
    rst_ni = 0;
    req.valid = 0; req.data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty errors, saturation, full list, unused codes
    send(REQ_POP, 0, 0);
    send(REQ_DELETE, 5, 0);
    send(REQ_APPEND, 0, 32'hffff_ffff);
    send(REQ_PREPEND, 0, 32'h0);
    send(REQ_INSERT, KEY_MIN, 32'h1234_5678);
    send(REQ_PREPEND, 0, 32'haaaa_5555);
    send(REQ_DELETE, KEY_MIN, 0);
    send(REQ_DELETE, KEY_MIN, 0);
    send(3'd5, KEY_MAX, 32'hffff_ffff);
    send(3'd7, 0, 0);
    send(REQ_POP, 0, 0);
    apb_write(KEY_MAX);
    send(REQ_POP, 0, 0);
    send(REQ_APPEND, 0, 1);
    send(REQ_APPEND, 0, 2);
    send(REQ_INSERT, KEY_MAX, 3);
    send(REQ_DELETE, KEY_MAX, 0);
    send(3'd6, 0, 0);
    while (sb.count() < 32) send(REQ_INSERT, rand_key(2), $urandom);
    send(REQ_APPEND, 0, 0);
    send(REQ_PREPEND, 0, 0);
    send(REQ_INSERT, 0, 0);
    while (sb.count() > 0) send(REQ_POP, 0, 0);
    apb_write(KEY_MIN);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: apb_write(0);
        2: apb_write($urandom);
        3: apb_write(KEY_MAX - 2);
        4: apb_write(KEY_MIN + 1);
        5: apb_write(32'sh0000_ffff);
        default: ;
      endcase
      mode = phase % 3;
      fill = $urandom_range(4, 30);
      for (int n = 0; n < 178; n++) begin
        t = $urandom_range(0, 99);
        if (t < 3) begin
          send(3'($urandom_range(5, 7)), $urandom, $urandom);
        end else if (sb.count() < fill ? t < 70 : t < 35) begin
          send(3'($urandom_range(0, 2)), rand_key(mode), $urandom);
        end else if (t < 80 && sb.count() > 0) begin
          k = sb.keys[$urandom_range(0, sb.count() - 1)];
          send(REQ_DELETE, k, $urandom);
        end else if (t < 86) begin
          send(REQ_DELETE, rand_key(mode), $urandom);
        end else begin
          send(REQ_POP, $urandom, $urandom);
        end
      end
    end

    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_key_priority_list test passed");
    end else begin
      $display("sorted_key_priority_list test failed");
    end
    $finish;
  end
endmodule
